/* rtl/core/mrfd_pkg.sv */
// Package for the meter response frame decoder.
// Holds frame constants, status codes, the CRC-16 lookup table and shared types.
// No dependencies.
package mrfd_pkg;

    localparam int unsigned FRAME_BYTES = 25;
    localparam int unsigned COUNT_W     = 5;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Byte positions of the first byte of each register field
    localparam logic [COUNT_W-1:0] POS_VOLTAGE = 5'd3;
    localparam logic [COUNT_W-1:0] POS_CURRENT = 5'd5;
    localparam logic [COUNT_W-1:0] POS_POWER   = 5'd9;
    localparam logic [COUNT_W-1:0] POS_ENERGY  = 5'd13;
    localparam logic [COUNT_W-1:0] POS_FREQ    = 5'd17;
    localparam logic [COUNT_W-1:0] POS_PF      = 5'd19;
    localparam logic [COUNT_W-1:0] POS_ALARM   = 5'd21;

    localparam logic [COUNT_W-1:0] FRAME_LAST_COUNT = COUNT_W'(FRAME_BYTES);
    localparam logic [COUNT_W-1:0] MIN_CRC_COUNT    = 5'd3;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_BAD_CRC = 2'd1,
        STAT_SHORT   = 2'd2
    } frame_status_t;

    typedef logic [15:0] crc_table_t [256];

    function automatic crc_table_t crc_build_table();
        crc_table_t  tbl;
        logic [15:0] c;
        for (int idx = 0; idx < 256; idx++) begin
            c = 16'(idx);
            for (int i = 0; i < 8; i++) begin
                c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
            end
            tbl[idx] = c;
        end
        return tbl;
    endfunction

    localparam crc_table_t CRC_TABLE = crc_build_table();

    // Step control handed from the top level to the state modules
    typedef struct packed {
        logic take;   // byte falls within the frame, update state
        logic close;  // item ends the frame, return state to reset values
    } step_t;

    typedef struct packed {
        logic [15:0] voltage;
        logic [31:0] current;
        logic [31:0] power;
        logic [31:0] energy;
        logic [15:0] frequency;
        logic [15:0] power_factor;
        logic [15:0] alarm;
    } fields_t;

endpackage

/* rtl/core/mrfd_crc.sv */
// CRC-16/Modbus tracker for the meter response frame decoder.
// Keeps the running CRC, the CRC two bytes back and the last two bytes.
// Depends on mrfd_pkg.
module mrfd_crc
    import mrfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  step_t       step,
    input  logic [7:0]  rx_byte,
    output logic        crc_match
);

    logic [15:0] acc_reg,  acc_next;
    logic [15:0] dly0_reg, dly0_next;
    logic [15:0] dly1_reg, dly1_next;
    logic [15:0] last_reg, last_next;

    always_comb
    begin
        acc_next  = acc_reg;
        dly0_next = dly0_reg;
        dly1_next = dly1_reg;
        last_next = last_reg;
        if (step.take)
        begin
            dly1_next = dly0_reg;
            dly0_next = acc_reg;
            acc_next  = (acc_reg >> 8) ^ CRC_TABLE[rx_byte ^ acc_reg[7:0]];
            last_next = {last_reg[7:0], rx_byte};
        end
    end

    // Checksum travels low byte first: the older byte is the low half
    assign crc_match = ({last_next[7:0], last_next[15:8]} == dly1_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= CRC_INIT;
            dly0_reg <= CRC_INIT;
            dly1_reg <= CRC_INIT;
            last_reg <= '0;
        end
        else if (step.close)
        begin
            acc_reg  <= CRC_INIT;
            dly0_reg <= CRC_INIT;
            dly1_reg <= CRC_INIT;
            last_reg <= '0;
        end
        else
        begin
            acc_reg  <= acc_next;
            dly0_reg <= dly0_next;
            dly1_reg <= dly1_next;
            last_reg <= last_next;
        end
    end

endmodule

/* rtl/core/mrfd_capture.sv */
// Byte counter and register field capture for the meter response frame decoder.
// Drops each byte into its field lane by frame position.
// Depends on mrfd_pkg.
module mrfd_capture
    import mrfd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  step_t              step,
    input  logic [7:0]         rx_byte,
    output logic [COUNT_W-1:0] count,
    output logic [COUNT_W-1:0] count_next,
    output fields_t            fields_next
);

    logic [COUNT_W-1:0] count_reg;
    fields_t            held_reg;

    assign count      = count_reg;
    assign count_next = step.take ? count_reg + 1'b1 : count_reg;

    always_comb
    begin
        fields_next = held_reg;
        if (step.take)
        begin
            case (count_reg)
                POS_VOLTAGE:          fields_next.voltage[15:8]      = rx_byte;
                POS_VOLTAGE + 5'd1:   fields_next.voltage[7:0]       = rx_byte;
                POS_CURRENT:          fields_next.current[15:8]      = rx_byte;
                POS_CURRENT + 5'd1:   fields_next.current[7:0]       = rx_byte;
                POS_CURRENT + 5'd2:   fields_next.current[31:24]     = rx_byte;
                POS_CURRENT + 5'd3:   fields_next.current[23:16]     = rx_byte;
                POS_POWER:            fields_next.power[15:8]        = rx_byte;
                POS_POWER + 5'd1:     fields_next.power[7:0]         = rx_byte;
                POS_POWER + 5'd2:     fields_next.power[31:24]       = rx_byte;
                POS_POWER + 5'd3:     fields_next.power[23:16]       = rx_byte;
                POS_ENERGY:           fields_next.energy[15:8]       = rx_byte;
                POS_ENERGY + 5'd1:    fields_next.energy[7:0]        = rx_byte;
                POS_ENERGY + 5'd2:    fields_next.energy[31:24]      = rx_byte;
                POS_ENERGY + 5'd3:    fields_next.energy[23:16]      = rx_byte;
                POS_FREQ:             fields_next.frequency[15:8]    = rx_byte;
                POS_FREQ + 5'd1:      fields_next.frequency[7:0]     = rx_byte;
                POS_PF:               fields_next.power_factor[15:8] = rx_byte;
                POS_PF + 5'd1:        fields_next.power_factor[7:0]  = rx_byte;
                POS_ALARM:            fields_next.alarm[15:8]        = rx_byte;
                POS_ALARM + 5'd1:     fields_next.alarm[7:0]         = rx_byte;
                default:              fields_next = held_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            held_reg  <= '0;
        end
        else if (step.close)
        begin
            count_reg <= '0;
            held_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            held_reg  <= fields_next;
        end
    end

endmodule

/* rtl/core/meter_response_frame_decoder_unit.sv */
// Top level of the meter response frame decoder.
// Input register, CRC tracker, field capture, status decision and result register.
// Depends on mrfd_pkg, mrfd_crc and mrfd_capture.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+------------------------------------------
//  s_*      | in        | s_tvalid/s_tready  | tdata: rx_byte; tlast: end_of_frame
//  m_*      | out       | m_tvalid/m_tready  | tuser: frame_status; tdata: count + fields
//
// One item per cycle sustained while no closing item waits. An item is registered on
// entry and processed from the input register; a frame's result is loaded into the result
// register when its closing item is processed. Reset returns the CRC to 0xFFFF and clears
// the count and held fields; no clearing pass is needed. Only a closing item waits on a
// full result register, so ordinary bytes keep flowing while a result sits unread.
module meter_response_frame_decoder_unit
    import mrfd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] rx_byte
    input  logic         s_tlast,   // end_of_frame
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [167:0] m_tdata,   // [4:0] byte_count, [20:5] voltage_raw,
                                    // [52:21] current_raw, [84:53] power_raw,
                                    // [116:85] energy_raw, [132:117] frequency_raw,
                                    // [148:133] power_factor_raw, [164:149] alarm_raw,
                                    // [167:165] zero
    output logic [1:0]   m_tuser    // [1:0] frame_status
);

    // Input register
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // Result register
    logic               out_valid_reg, out_valid_next;
    frame_status_t      out_status_reg;
    logic [COUNT_W-1:0] out_count_reg;
    fields_t            out_fields_reg;

    logic               go;
    step_t              step;
    logic               crc_match;
    logic [COUNT_W-1:0] count;
    logic [COUNT_W-1:0] count_next;
    fields_t            fields_next;
    frame_status_t      status;

    // A closing item needs a free result slot; plain bytes never wait
    assign go       = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || go;

    assign step = '{take: go && (count < FRAME_LAST_COUNT), close: go && in_last_reg};

    mrfd_crc u_crc (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .rx_byte   (in_byte_reg),
        .crc_match (crc_match)
    );

    mrfd_capture u_capture (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .rx_byte     (in_byte_reg),
        .count       (count),
        .count_next  (count_next),
        .fields_next (fields_next)
    );

    // Decide status from the state as it stands after this byte
    always_comb
    begin
        if (count_next < MIN_CRC_COUNT || !crc_match)
            status = STAT_BAD_CRC;
        else if (count_next < FRAME_LAST_COUNT)
            status = STAT_SHORT;
        else
            status = STAT_OK;
    end

    assign in_valid_next  = (s_tvalid && s_tready) ? 1'b1 : (in_valid_reg && !go);
    assign out_valid_next = step.close ? 1'b1 : (out_valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the input item until it is processed
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // Load the result; zero the fields of a failed frame
    always_ff @(posedge clk)
    begin
        if (step.close)
        begin
            out_status_reg <= status;
            out_count_reg  <= count_next;
            out_fields_reg <= (status == STAT_OK) ? fields_next : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {3'd0,
                       out_fields_reg.alarm,
                       out_fields_reg.power_factor,
                       out_fields_reg.frequency,
                       out_fields_reg.energy,
                       out_fields_reg.power,
                       out_fields_reg.current,
                       out_fields_reg.voltage,
                       out_count_reg};

endmodule
